[src/lrdc_pkg.sv]
package lrdc_pkg;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_DESC  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CRC = 2'd1,
        ST_TRUNC   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_KEY    = 2'd1,
        PH_VALUE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        t_kind        item_kind;
        logic [7:0]   byte_out;
        t_status      status;
        logic         is_deleted;
        logic [31:0]  record_version;
        logic [15:0]  key_length;
        logic [31:0]  value_length;
        logic [47:0]  record_offset;
        logic [47:0]  value_offset;
        logic         run_last;
    } t_out_item;

    // up to two results per input transfer go into the result queue
    typedef struct packed {
        logic      en0;
        logic      en1;
        t_out_item item0;
        t_out_item item1;
    } t_q_push;

    localparam int LRDC_Q_DEPTH = 4;
    localparam int LRDC_CRC_BYTES = 4;
    localparam logic [31:0] LRDC_CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] LRDC_CRC_POLY = 32'hEDB8_8320;

    // reflected CRC-32, one byte
    function automatic logic [31:0] lrdc_crc_byte(input logic [31:0] crc_in,
                                                  input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ LRDC_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/lrdc_if.sv]
interface lrdc_in_if;
    import lrdc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lrdc_out_if;
    import lrdc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/lrdc_result_q.sv]
module lrdc_result_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lrdc_pkg::t_q_push i_push,
    output logic             o_room,
    lrdc_out_if.source       o_out
);
    import lrdc_pkg::*;

    localparam int PW = $clog2(LRDC_Q_DEPTH);

    t_out_item      r_mem [LRDC_Q_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [PW:0]    n_cnt;
    logic           w_pop;

    assign w_pop       = o_out.valid && o_out.ready;
    assign o_out.valid = (r_cnt != '0);
    assign o_out.payload = r_mem[r_rd];
    // room for two results at once
    assign o_room = (r_cnt <= (PW + 1)'(LRDC_Q_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + PW'(i_push.en0) + PW'(i_push.en1);
        n_rd  = r_rd + PW'(w_pop);
        n_cnt = r_cnt + (PW + 1)'(i_push.en0) + (PW + 1)'(i_push.en1)
                - (PW + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.en1) begin
            r_mem[r_wr + PW'(1)] <= i_push.item1;
        end
    end

endmodule

[src/log_record_deframe_check.sv]
// Record stream deframer with CRC-32 check. Takes one stream byte per input
// transfer and parses back-to-back records: a big-endian header (4-byte CRC,
// version, key length, value length), then key bytes, then value bytes. Key
// and value bytes come out tagged as they arrive; at each record end a
// descriptor follows with lengths, version, offsets, the deleted flag (value
// length all ones, no value bytes) and the CRC status. The CRC is reflected
// CRC-32 over the header after its CRC field, the key and the value. A CRC
// mismatch halts parsing until stream_end; a stream_end inside a record gives
// one truncation status. Every stream_end resets the parser.
// Rate: one input transfer per cycle while the queue has room. Results sit in
// a four-entry queue and leave at one per cycle while the sink is ready.
// Input ready depends only on queue fill: the queue must hold room for two
// results, since the byte that ends a record also produces its descriptor.
// That extra result is drained during the next record's header bytes, which
// produce nothing, so with no sink stall records run at one byte per cycle.
module log_record_deframe_check #(
    parameter int KEY_LEN_BYTES   = 2,
    parameter int VALUE_LEN_BYTES = 4,
    parameter int VERSION_BYTES   = 4,
    parameter int OFFSET_BITS     = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrdc_in_if.sink    i_in,
    lrdc_out_if.source o_out
);
    import lrdc_pkg::*;

    localparam int KL_W = 8 * KEY_LEN_BYTES;
    localparam int VL_W = 8 * VALUE_LEN_BYTES;
    localparam int VER_W = 8 * VERSION_BYTES;
    // header byte boundaries
    localparam int VER_END = LRDC_CRC_BYTES + VERSION_BYTES;
    localparam int KL_END = VER_END + KEY_LEN_BYTES;
    localparam int HDR_BYTES = KL_END + VALUE_LEN_BYTES;
    localparam logic [VL_W-1:0] DEL_MARK = '1;

    // parser state
    t_phase                 r_phase;
    logic [31:0]            r_count;
    logic [31:0]            r_crc;
    logic [31:0]            r_stored;
    logic [VER_W-1:0]       r_ver;
    logic [KL_W-1:0]        r_klen;
    logic [VL_W-1:0]        r_vlen;
    logic [OFFSET_BITS-1:0] r_off;
    logic [OFFSET_BITS-1:0] r_rec_start;
    logic [OFFSET_BITS-1:0] r_val_start;
    logic                   r_halted;

    t_phase                 n_phase;
    logic [31:0]            n_count;
    logic [31:0]            n_crc;
    logic [31:0]            n_stored;
    logic [VER_W-1:0]       n_ver;
    logic [KL_W-1:0]        n_klen;
    logic [VL_W-1:0]        n_vlen;
    logic [OFFSET_BITS-1:0] n_off;
    logic [OFFSET_BITS-1:0] n_rec_start;
    logic [OFFSET_BITS-1:0] n_val_start;
    logic                   n_halted;

    logic    w_fire;
    logic    w_room;
    t_q_push w_push;

    assign w_fire     = i_in.valid && i_in.ready;
    assign i_in.ready = w_room;

    always_comb begin
        logic [7:0]             b;
        logic [31:0]            crc_b;
        logic [OFFSET_BITS-1:0] nxt;
        logic                   emit_byte;
        logic                   go_after_key;
        logic                   do_finish;
        logic                   bad;
        logic                   del;
        t_out_item              byte_item;
        t_out_item              desc;

        b            = i_in.payload.data_byte;
        crc_b        = lrdc_crc_byte(r_crc, b);
        nxt          = r_off + OFFSET_BITS'(1);
        emit_byte    = 1'b0;
        go_after_key = 1'b0;
        do_finish    = 1'b0;
        bad          = 1'b0;
        del          = 1'b0;
        byte_item    = '0;
        desc         = '0;

        n_phase     = r_phase;
        n_count     = r_count;
        n_crc       = r_crc;
        n_stored    = r_stored;
        n_ver       = r_ver;
        n_klen      = r_klen;
        n_vlen      = r_vlen;
        n_off       = r_off;
        n_rec_start = r_rec_start;
        n_val_start = r_val_start;
        n_halted    = r_halted;
        w_push      = '0;

        if (w_fire && i_in.payload.stream_end) begin
            // truncated record: only when bytes of it were taken
            if (!r_halted && (r_phase != PH_HEADER || r_count != '0)) begin
                w_push.en0                 = 1'b1;
                w_push.item0.item_kind     = KIND_DESC;
                w_push.item0.status        = ST_TRUNC;
                w_push.item0.record_offset = 48'(64'(r_rec_start));
                w_push.item0.run_last      = 1'b1;
            end
            n_phase     = PH_HEADER;
            n_count     = '0;
            n_crc       = LRDC_CRC_INIT;
            n_stored    = '0;
            n_ver       = '0;
            n_klen      = '0;
            n_vlen      = '0;
            n_off       = '0;
            n_rec_start = '0;
            n_val_start = '0;
            n_halted    = 1'b0;
        end else if (w_fire && !r_halted) begin
            n_off = nxt;
            case (r_phase)
                PH_HEADER: begin
                    if (r_count == '0) begin
                        n_rec_start = r_off;
                    end
                    if (r_count < 32'(LRDC_CRC_BYTES)) begin
                        n_stored = {r_stored[23:0], b};
                    end else begin
                        n_crc = crc_b;
                        if (r_count < 32'(VER_END)) begin
                            n_ver = VER_W'({r_ver, b});
                        end else if (r_count < 32'(KL_END)) begin
                            n_klen = KL_W'({r_klen, b});
                        end else begin
                            n_vlen = VL_W'({r_vlen, b});
                        end
                    end
                    n_count = r_count + 32'd1;
                    if (r_count == 32'(HDR_BYTES - 1)) begin
                        n_count = '0;
                        if (n_klen != '0) begin
                            n_phase = PH_KEY;
                        end else begin
                            go_after_key = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    n_crc               = crc_b;
                    emit_byte           = 1'b1;
                    byte_item.item_kind = KIND_KEY;
                    byte_item.byte_out  = b;
                    n_count             = r_count + 32'd1;
                    if (n_count == 32'(r_klen)) begin
                        go_after_key = 1'b1;
                    end
                end
                PH_VALUE: begin
                    n_crc               = crc_b;
                    emit_byte           = 1'b1;
                    byte_item.item_kind = KIND_VALUE;
                    byte_item.byte_out  = b;
                    n_count             = r_count + 32'd1;
                    if (n_count == 32'(r_vlen)) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase

            // key done (or empty): value next, or record ends here
            if (go_after_key) begin
                n_val_start = nxt;
                if (n_vlen != DEL_MARK && n_vlen != '0) begin
                    n_phase = PH_VALUE;
                    n_count = '0;
                end else begin
                    do_finish = 1'b1;
                end
            end

            if (do_finish) begin
                bad                 = ((~n_crc) != n_stored);
                del                 = (n_vlen == DEL_MARK);
                desc.item_kind      = KIND_DESC;
                desc.status         = bad ? ST_BAD_CRC : ST_OK;
                desc.is_deleted     = del;
                desc.record_version = 32'(n_ver);
                desc.key_length     = 16'(32'(n_klen));
                desc.value_length   = del ? 32'd0 : 32'(n_vlen);
                desc.record_offset  = 48'(64'(r_rec_start));
                desc.value_offset   = del ? 48'd0 : 48'(64'(n_val_start));
                desc.run_last       = 1'b1;
                // next record starts fresh
                n_phase  = PH_HEADER;
                n_count  = '0;
                n_crc    = LRDC_CRC_INIT;
                n_stored = '0;
                n_ver    = '0;
                n_klen   = '0;
                n_vlen   = '0;
                n_halted = bad;
            end

            // byte first, descriptor behind it
            if (emit_byte) begin
                byte_item.run_last = !do_finish;
                w_push.en0         = 1'b1;
                w_push.item0       = byte_item;
                w_push.en1         = do_finish;
                w_push.item1       = desc;
            end else begin
                w_push.en0   = do_finish;
                w_push.item0 = desc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= '0;
            r_crc       <= LRDC_CRC_INIT;
            r_stored    <= '0;
            r_ver       <= '0;
            r_klen      <= '0;
            r_vlen      <= '0;
            r_off       <= '0;
            r_rec_start <= '0;
            r_val_start <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_stored    <= n_stored;
            r_ver       <= n_ver;
            r_klen      <= n_klen;
            r_vlen      <= n_vlen;
            r_off       <= n_off;
            r_rec_start <= n_rec_start;
            r_val_start <= n_val_start;
            r_halted    <= n_halted;
        end
    end

    lrdc_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

    // second result slot only used behind the first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.en1 |-> w_push.en0)
        else $error("second result pushed without first");

    // halted parser drops bytes silently
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_in.payload.stream_end && r_halted) |-> !w_push.en0)
        else $error("result while halted");

    // checksum mismatch halts the parser
    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_in.payload.stream_end && w_push.en0
         && (w_push.item0.status == ST_BAD_CRC
             || (w_push.en1 && w_push.item1.status == ST_BAD_CRC)))
        |=> r_halted)
        else $error("mismatch did not halt");

    // stream end leaves a clean parser
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_in.payload.stream_end)
        |=> (r_phase == PH_HEADER && r_count == '0 && !r_halted))
        else $error("parser not reset after stream end");

    // no push without queue room
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_room |-> !w_push.en0)
        else $error("push into full result queue");

endmodule

[test/tb_log_record_deframe_check.sv]
module tb_log_record_deframe_check;
    import lrdc_pkg::*;

    // Record layout at the default parameters: 4 CRC bytes, 4 version bytes,
    // 2 key length bytes, 4 value length bytes.
    localparam int          CRC_LEN      = 4;
    localparam int          VER_END      = 8;
    localparam int          KLEN_END     = 10;
    localparam int          HDR_LEN      = 14;
    localparam logic [31:0] DEL_LEN      = 32'hFFFF_FFFF;
    localparam int          TARGET_BYTES = 1800;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          LIMIT_CYCLES = 600000;

    // One line of stimulus: a record (or part of one), bytes ignored after
    // it, and an optional stream end. cut < 0 sends the whole record,
    // cut == 0 sends no record at all.
    typedef struct {
        logic [31:0] ver;
        logic [15:0] klen;
        logic [31:0] vlen;
        bit          bad;
        int          cut;
        int          noise;
        bit          end_after;
        bit          typed;
        t_out_item   want;
    } t_case;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lrdc_in_if  in_if ();
    lrdc_out_if out_if ();

    log_record_deframe_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // parser state mirror
    t_phase      ph;
    int unsigned field_pos;
    logic [31:0] crc_run;
    logic [31:0] crc_hdr;
    logic [31:0] ver_hold;
    logic [15:0] klen_hold;
    logic [31:0] vlen_hold;
    logic [47:0] byte_pos;
    logic [47:0] rec_base;
    logic [47:0] val_base;
    logic        halt_flag;

    t_out_item step_out[$];         // results of the current transfer
    t_out_item pending_results[$];  // expected results, oldest first

    bit        typed_active;        // typed-in descriptor overrides the mirror
    t_out_item typed_want;
    bit        calm;                // no idling on either side
    int        sent_bytes;
    int        mismatches = 0;
    int        sink_hold;
    int        cycle_count = 0;
    t_out_item seen_want;

    // Reflected CRC-32, one bit at a time, LSB first.
    function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = r >> 1;
            if (fb) begin
                r = r ^ 32'hEDB8_8320;
            end
        end
        return r;
    endfunction

    function automatic t_out_item mk_desc(t_status st, logic del, logic [31:0] ver,
                                          logic [15:0] kl, logic [31:0] vl,
                                          logic [47:0] ro, logic [47:0] vo);
        t_out_item d;
        d                = '0;
        d.item_kind      = KIND_DESC;
        d.status         = st;
        d.is_deleted     = del;
        d.record_version = ver;
        d.key_length     = kl;
        d.value_length   = vl;
        d.record_offset  = ro;
        d.value_offset   = vo;
        d.run_last       = 1'b1;
        return d;
    endfunction

    function automatic t_out_item mk_data(t_kind kind, logic [7:0] b);
        t_out_item d;
        d           = '0;
        d.item_kind = kind;
        d.byte_out  = b;
        return d;
    endfunction

    function automatic void restart_record();
        ph        = PH_HEADER;
        field_pos = 0;
        crc_run   = 32'hFFFF_FFFF;
        crc_hdr   = '0;
        ver_hold  = '0;
        klen_hold = '0;
        vlen_hold = '0;
    endfunction

    function automatic void clear_parser();
        restart_record();
        byte_pos  = '0;
        rec_base  = '0;
        val_base  = '0;
        halt_flag = 1'b0;
    endfunction

    // Descriptor at record end; a bad CRC halts until stream end.
    function automatic void close_record();
        logic del;
        logic bad;
        del = (vlen_hold == DEL_LEN);
        bad = (~crc_run != crc_hdr);
        step_out.push_back(mk_desc(bad ? ST_BAD_CRC : ST_OK, del, ver_hold, klen_hold,
                                   del ? 32'd0 : vlen_hold, rec_base,
                                   del ? 48'd0 : val_base));
        if (bad) begin
            halt_flag = 1'b1;
        end
        restart_record();
    endfunction

    function automatic void key_done(logic [47:0] nxt);
        val_base = nxt;
        if (vlen_hold != DEL_LEN && vlen_hold != 32'd0) begin
            ph        = PH_VALUE;
            field_pos = 0;
        end else begin
            close_record();
        end
    endfunction

    // Mirror of one input transfer; fills step_out.
    function automatic void deframe_step(logic [7:0] b, logic e);
        logic [47:0] pos;
        step_out.delete();
        if (e) begin
            if (!halt_flag && (ph != PH_HEADER || field_pos != 0)) begin
                step_out.push_back(mk_desc(ST_TRUNC, 1'b0, '0, '0, '0, rec_base, '0));
            end
            clear_parser();
        end else if (!halt_flag) begin
            pos      = byte_pos;
            byte_pos = pos + 48'd1;
            case (ph)
                PH_HEADER: begin
                    if (field_pos == 0) begin
                        rec_base = pos;
                    end
                    if (field_pos < CRC_LEN) begin
                        crc_hdr = {crc_hdr[23:0], b};
                    end else begin
                        crc_run = crc32_update(crc_run, b);
                        if (field_pos < VER_END) begin
                            ver_hold = {ver_hold[23:0], b};
                        end else if (field_pos < KLEN_END) begin
                            klen_hold = {klen_hold[7:0], b};
                        end else begin
                            vlen_hold = {vlen_hold[23:0], b};
                        end
                    end
                    field_pos++;
                    if (field_pos >= HDR_LEN) begin
                        field_pos = 0;
                        if (klen_hold != 16'd0) begin
                            ph = PH_KEY;
                        end else begin
                            key_done(byte_pos);
                        end
                    end
                end
                PH_KEY: begin
                    crc_run = crc32_update(crc_run, b);
                    step_out.push_back(mk_data(KIND_KEY, b));
                    field_pos++;
                    if (field_pos >= klen_hold) begin
                        key_done(byte_pos);
                    end
                end
                default: begin
                    crc_run = crc32_update(crc_run, b);
                    step_out.push_back(mk_data(KIND_VALUE, b));
                    field_pos++;
                    if (field_pos >= vlen_hold) begin
                        close_record();
                    end
                end
            endcase
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].run_last = 1'b1;
        end
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic t_case mk_case(logic [31:0] ver, logic [15:0] kl, logic [31:0] vl,
                                      bit bad, int cut, int noise, bit fin,
                                      bit typed, t_out_item want);
        t_case c;
        c.ver       = ver;
        c.klen      = kl;
        c.vlen      = vl;
        c.bad       = bad;
        c.cut       = cut;
        c.noise     = noise;
        c.end_after = fin;
        c.typed     = typed;
        c.want      = want;
        return c;
    endfunction

    function automatic bit item_matches(t_out_item w, t_out_item a);
        return w.item_kind === a.item_kind && w.byte_out === a.byte_out
            && w.status === a.status && w.is_deleted === a.is_deleted
            && w.record_version === a.record_version && w.key_length === a.key_length
            && w.value_length === a.value_length && w.record_offset === a.record_offset
            && w.value_offset === a.value_offset && w.run_last === a.run_last;
    endfunction

    function automatic void note_mismatch(bit have_want, t_out_item w, t_out_item a);
        mismatches++;
        if (mismatches <= 10) begin
            if (have_want) begin
                $display("mismatch: want kind=%0d byte=%02h st=%0d del=%0b ver=%08h",
                         w.item_kind, w.byte_out, w.status, w.is_deleted, w.record_version);
                $display("  klen=%0d vlen=%0d roff=%0h voff=%0h last=%0b",
                         w.key_length, w.value_length, w.record_offset, w.value_offset,
                         w.run_last);
            end else begin
                $display("mismatch: result with nothing expected");
            end
            $display("  got  kind=%0d byte=%02h st=%0d del=%0b ver=%08h",
                     a.item_kind, a.byte_out, a.status, a.is_deleted, a.record_version);
            $display("  klen=%0d vlen=%0d roff=%0h voff=%0h last=%0b",
                     a.key_length, a.value_length, a.record_offset, a.value_offset,
                     a.run_last);
        end
    endfunction

    // One input transfer: optional gap, hold until ready, then update the
    // mirror. Entered and left at a falling edge.
    task automatic send_item(logic [7:0] b, logic e);
        int       gap;
        t_in_item p;
        gap          = idle_len();
        p.data_byte  = b;
        p.stream_end = e;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= p;
        do @(posedge i_clk); while (!in_if.ready);
        deframe_step(b, e);
        foreach (step_out[k]) begin
            // typed-in rows replace the mirror's descriptor by hand-written values
            if (typed_active && step_out[k].item_kind == KIND_DESC) begin
                pending_results.push_back(typed_want);
            end else begin
                pending_results.push_back(step_out[k]);
            end
        end
        @(negedge i_clk);
    endtask

    // Builds a record with a real CRC (or one with a flipped bit), sends all
    // of it or a prefix, then ignored bytes and a stream end if asked.
    task automatic run_case(t_case c);
        logic [7:0]  rec[$];
        logic [31:0] crc;
        longint      nbody;
        int          nsend;
        typed_active = c.typed;
        typed_want   = c.want;
        if (c.cut != 0) begin
            rec = {c.ver[31:24], c.ver[23:16], c.ver[15:8], c.ver[7:0],
                   c.klen[15:8], c.klen[7:0],
                   c.vlen[31:24], c.vlen[23:16], c.vlen[15:8], c.vlen[7:0]};
            nbody = longint'(c.klen) + ((c.vlen == DEL_LEN) ? 64'd0 : longint'(c.vlen));
            // huge lengths only ever go out as a short prefix
            if (nbody > 256) begin
                nbody = 64;
            end
            repeat (nbody) rec.push_back(8'($urandom_range(0, 255)));
            crc = 32'hFFFF_FFFF;
            foreach (rec[k]) begin
                crc = crc32_update(crc, rec[k]);
            end
            crc = ~crc;
            if (c.bad) begin
                crc = crc ^ (32'd1 << $urandom_range(0, 31));
            end
            rec.push_front(crc[7:0]);
            rec.push_front(crc[15:8]);
            rec.push_front(crc[23:16]);
            rec.push_front(crc[31:24]);
            nsend = (c.cut < 0 || c.cut > rec.size()) ? rec.size() : c.cut;
            for (int k = 0; k < nsend; k++) begin
                send_item(rec[k], 1'b0);
            end
            sent_bytes += nsend;
        end
        repeat (c.noise) send_item(8'($urandom_range(0, 255)), 1'b0);
        if (c.end_after) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        typed_active = 1'b0;
    endtask

    // Result sink: random stalls, none while calm.
    initial begin
        out_if.ready = 1'b0;
        sink_hold    = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                out_if.ready <= 1'b0;
            end else begin
                sink_hold = idle_len();
                if (sink_hold > 0) begin
                    sink_hold--;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // Every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch(1'b0, '0, out_if.payload);
            end else begin
                seen_want = pending_results.pop_front();
                if (!item_matches(seen_want, out_if.payload)) begin
                    note_mismatch(1'b1, seen_want, out_if.payload);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL log_record_deframe_check");
            $finish;
        end
    end

    initial begin
        t_case       plan[$];
        t_case       c;
        int          r;
        int          pick;
        int          len;
        logic [15:0] kl;
        logic [31:0] vl;
        logic [31:0] ver;

        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        calm          = 1'b0;
        sent_bytes    = 0;
        typed_active  = 1'b0;
        typed_want    = '0;
        clear_parser();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Rows with a typed descriptor end with a stream end,
        // so the next record starts at offset 0.
        //                      ver           klen     vlen      bad cut noise end typed
        plan.push_back(mk_case(32'h0,        16'd0,    32'd0,        0, 0,  0, 1, 0, '0));
        plan.push_back(mk_case(32'h0,        16'd0,    32'd0,        0, -1, 0, 1, 1,
                               mk_desc(ST_OK, 0, 32'h0, 16'd0, 32'd0, 48'd0, 48'd14)));
        plan.push_back(mk_case(32'hFFFF_FFFF, 16'd0,   DEL_LEN,      0, -1, 0, 1, 1,
                               mk_desc(ST_OK, 1, 32'hFFFF_FFFF, 16'd0, 32'd0, 48'd0, 48'd0)));
        // bad CRC: halts, the following bytes are dropped, end gives nothing
        plan.push_back(mk_case(32'h1234_5678, 16'd1,   32'd1,        1, -1, 4, 1, 1,
                               mk_desc(ST_BAD_CRC, 0, 32'h1234_5678, 16'd1, 32'd1,
                                       48'd0, 48'd15)));
        // largest lengths, stream ends inside the key
        plan.push_back(mk_case(32'h0,        16'hFFFF, 32'hFFFF_FFFE, 0, 20, 0, 1, 1,
                               mk_desc(ST_TRUNC, 0, '0, '0, '0, 48'd0, 48'd0)));
        plan.push_back(mk_case(32'h1,        16'd3,    DEL_LEN,      0, -1, 0, 1, 1,
                               mk_desc(ST_OK, 1, 32'h1, 16'd3, 32'd0, 48'd0, 48'd0)));
        plan.push_back(mk_case(32'hA5A5_5A5A, 16'd2,   32'd2,        0, 1,  0, 1, 1,
                               mk_desc(ST_TRUNC, 0, '0, '0, '0, 48'd0, 48'd0)));
        plan.push_back(mk_case(32'h0,        16'd0,    32'hFFFF_FFFE, 0, 30, 0, 1, 1,
                               mk_desc(ST_TRUNC, 0, '0, '0, '0, 48'd0, 48'd0)));
        // back-to-back records, checked by the mirror
        plan.push_back(mk_case(32'h0BAD_F00D, 16'd2,   32'd3,        0, -1, 0, 0, 0, '0));
        plan.push_back(mk_case(32'h7FFF_FFFF, 16'd0,   32'd5,        0, -1, 0, 0, 0, '0));
        plan.push_back(mk_case(32'h8000_0000, 16'd4,   32'd0,        0, -1, 0, 0, 0, '0));
        plan.push_back(mk_case(32'h0000_0001, 16'd5,   DEL_LEN,      0, -1, 0, 0, 0, '0));
        plan.push_back(mk_case(32'hDEAD_BEEF, 16'd2,   32'd6,        0, 19, 0, 1, 0, '0));
        plan.push_back(mk_case(32'h5555_AAAA, 16'd3,   32'd2,        0, -1, 0, 0, 0, '0));
        plan.push_back(mk_case(32'hAAAA_5555, 16'd1,   32'd1,        1, -1, 3, 1, 0, '0));
        plan.push_back(mk_case(32'hFFFF_FFFF, 16'd8,   32'd8,        0, -1, 0, 1, 0, '0));

        foreach (plan[k]) begin
            run_case(plan[k]);
        end

        // Random part: mostly well-formed records with random content; some
        // with a bad CRC, cut short, with wild lengths, or bare stream ends.
        while (sent_bytes < TARGET_BYTES) begin
            if ($urandom_range(0, 99) < 3) begin
                calm = !calm;
            end
            pick = $urandom_range(0, 9);
            kl   = (pick < 6) ? 16'($urandom_range(0, 4))
                 : (pick < 9) ? 16'($urandom_range(5, 16)) : 16'($urandom_range(17, 40));
            pick = $urandom_range(0, 9);
            vl   = (pick < 2) ? DEL_LEN
                 : (pick < 8) ? 32'($urandom_range(0, 12)) : 32'($urandom_range(13, 48));
            ver  = $urandom();
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                ver = 32'h0;
            end else if (pick == 1) begin
                ver = 32'hFFFF_FFFF;
            end
            c = mk_case(ver, kl, vl, 0, -1, 0, ($urandom_range(0, 9) == 0), 0, '0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                c.bad       = 1;
                c.noise     = $urandom_range(0, 6);
                c.end_after = 1;
            end else if (r < 16) begin
                len         = HDR_LEN + kl + ((vl == DEL_LEN) ? 0 : int'(vl));
                c.cut       = $urandom_range(1, len - 1);
                c.end_after = 1;
            end else if (r < 19) begin
                c.klen      = 16'($urandom());
                c.vlen      = $urandom();
                c.cut       = $urandom_range(1, HDR_LEN + 40);
                c.end_after = 1;
            end else if (r < 22) begin
                c.cut       = 0;
                c.end_after = 1;
            end
            run_case(c);
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // catch stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS log_record_deframe_check");
        end else begin
            $display("FAIL log_record_deframe_check");
        end
        $finish;
    end

endmodule

[log_record_deframe_check.f]
src/lrdc_pkg.sv
src/lrdc_if.sv
src/lrdc_result_q.sv
src/log_record_deframe_check.sv
test/tb_log_record_deframe_check.sv
